[src/ste_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ste_pkg
// Shared types and constants of the sprite tile expander: field widths of
// the sprite entry, coordinate offsets and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ste_pkg;

    localparam int unsigned WordWidth  = 16;
    localparam int unsigned CodeWidth  = 12;
    localparam int unsigned PosWidth   = 9;
    localparam int unsigned ScrWidth   = 10;
    localparam int unsigned PalWidth   = 4;
    localparam int unsigned PmaskWidth = 7;
    localparam int unsigned RowWidth   = 3;
    localparam int unsigned ColWidth   = 2;
    localparam int unsigned RowShift   = 6;   // row step of 64 codes

    // fixed screen offsets: X and Y applied before the 9-bit wrap, bias after it
    localparam logic [PosWidth-1:0] XOffset   = 9'd6;
    localparam logic [PosWidth-1:0] YOffset   = 9'd10;
    localparam logic [ScrWidth-1:0] ScrBias   = 10'd8;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } ste_state_t;

    typedef struct packed {
        logic load;   // latch a new sprite entry, clear counters
        logic emit;   // load output register, step counters
    } ste_cmd_t;

    typedef struct packed {
        logic out_stall;  // output register full and not taken
        logic at_last;    // counters sit on the final tile
    } ste_status_t;

endpackage
`default_nettype wire

[src/sprite_tile_expander.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_tile_expander
// Expands one four-word sprite entry into a run of 8x8 tile draw commands.
// ----------------------------------------------------------------------------
// One item on the s_ side is a sprite entry (vertical, tile, attribute and
// horizontal words); it becomes W*H items on the m_ side for a sprite of
// W (1..4) by H (1..8) tiles, row by row and within a row column by column,
// the final one flagged by m_last_tile. For each sprite the block first takes
// the entry, then puts out one command per cycle while m_ready allows, out of the
// single output register, which holds while m_ready is low. The next entry is
// taken as soon as the last command of the current sprite is in the output
// register, even while that command still waits to be taken.
module sprite_tile_expander (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // sprite entry items
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [15:0]          s_word_vertical,
    input  wire logic [15:0]          s_word_tile,
    input  wire logic [15:0]          s_word_attribute,
    input  wire logic [15:0]          s_word_horizontal,
    // tile command items
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [11:0]               m_tile_code,
    output logic [3:0]                m_palette_index,
    output logic signed [9:0]         m_screen_x,
    output logic signed [9:0]         m_screen_y,
    output logic                      m_mirror_x,
    output logic                      m_mirror_y,
    output logic [6:0]                m_priority_mask,
    output logic                      m_shadow_flag,
    output logic                      m_opaque_flag,
    output logic                      m_last_tile
);

    // command and status between sequencer and datapath
    ste_pkg::ste_cmd_t    cmd;
    ste_pkg::ste_status_t status;

    // sequencer: idle takes an entry, run emits until the last tile
    ste_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // decode, counters, code and coordinate arithmetic, output register
    ste_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .word_vertical   (s_word_vertical),
        .word_tile       (s_word_tile),
        .word_attribute  (s_word_attribute),
        .word_horizontal (s_word_horizontal),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tile_code     (m_tile_code),
        .m_palette_index (m_palette_index),
        .m_screen_x      (m_screen_x),
        .m_screen_y      (m_screen_y),
        .m_mirror_x      (m_mirror_x),
        .m_mirror_y      (m_mirror_y),
        .m_priority_mask (m_priority_mask),
        .m_shadow_flag   (m_shadow_flag),
        .m_opaque_flag   (m_opaque_flag),
        .m_last_tile     (m_last_tile)
    );

endmodule
`default_nettype wire

[src/ste_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ste_ctrl
// Sequencing state machine: takes one sprite entry, then emits one tile
// command per cycle whenever the output register is free.
// ----------------------------------------------------------------------------
module ste_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ste_pkg::ste_status_t status,
    output ste_pkg::ste_cmd_t        cmd
);

    ste_pkg::ste_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ste_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ste_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ste_pkg::ST_RUN;
                end
            end
            ste_pkg::ST_RUN: begin
                if (!status.out_stall) begin
                    cmd.emit = 1'b1;
                    if (status.at_last) begin
                        state_next = ste_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ste_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[src/ste_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ste_datapath
// Decoded sprite entry, row/column counters, tile command arithmetic and the
// output register with its valid flag.
// ----------------------------------------------------------------------------
module ste_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ste_pkg::ste_cmd_t             cmd,
    output ste_pkg::ste_status_t               status,
    input  wire logic [ste_pkg::WordWidth-1:0] word_vertical,
    input  wire logic [ste_pkg::WordWidth-1:0] word_tile,
    input  wire logic [ste_pkg::WordWidth-1:0] word_attribute,
    input  wire logic [ste_pkg::WordWidth-1:0] word_horizontal,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [ste_pkg::CodeWidth-1:0]      m_tile_code,
    output logic [ste_pkg::PalWidth-1:0]       m_palette_index,
    output logic signed [ste_pkg::ScrWidth-1:0] m_screen_x,
    output logic signed [ste_pkg::ScrWidth-1:0] m_screen_y,
    output logic                               m_mirror_x,
    output logic                               m_mirror_y,
    output logic [ste_pkg::PmaskWidth-1:0]     m_priority_mask,
    output logic                               m_shadow_flag,
    output logic                               m_opaque_flag,
    output logic                               m_last_tile
);

    // decoded entry
    logic                              flip_y_reg, flip_x_reg, shadow_reg, opaque_reg;
    logic [ste_pkg::RowWidth-1:0]      hm1_reg;
    logic [ste_pkg::ColWidth-1:0]      wm1_reg;
    logic [ste_pkg::PosWidth-1:0]      ypos_reg, xpos_reg;
    logic [ste_pkg::CodeWidth-1:0]     base_reg;
    logic [ste_pkg::PalWidth-1:0]      pal_reg;
    logic [ste_pkg::PmaskWidth-1:0]    pmask_reg;

    // counters
    logic [ste_pkg::RowWidth-1:0]      row_reg, row_next;
    logic [ste_pkg::ColWidth-1:0]      col_reg, col_next;

    // output register
    logic                              valid_reg, valid_next;
    logic [ste_pkg::CodeWidth-1:0]     code_reg, code_next;
    logic [ste_pkg::ScrWidth-1:0]      sx_reg, sx_next, sy_reg, sy_next;
    logic                              last_reg;
    logic [ste_pkg::PalWidth-1:0]      out_pal_reg;
    logic                              out_mx_reg, out_my_reg;
    logic [ste_pkg::PmaskWidth-1:0]    out_pmask_reg;
    logic                              out_shadow_reg, out_opaque_reg;

    logic [ste_pkg::PmaskWidth:0]      pmask_wide;
    logic [ste_pkg::RowWidth-1:0]      cy_tile;
    logic [ste_pkg::ColWidth-1:0]      cx_tile;
    logic [ste_pkg::PosWidth-1:0]      x_wrap, y_wrap;
    logic                              row_end, col_end;

    assign row_end = (row_reg == hm1_reg);
    assign col_end = (col_reg == wm1_reg);

    assign status.at_last   = row_end && col_end;
    assign status.out_stall = valid_reg && !m_ready;

    // 2^p - 1, p = 7 gives all ones
    assign pmask_wide = (ste_pkg::PmaskWidth+1)'(1) << word_attribute[2:0];

    always_comb begin
        cy_tile  = flip_y_reg ? (hm1_reg - row_reg) : row_reg;
        cx_tile  = flip_x_reg ? (wm1_reg - col_reg) : col_reg;
        x_wrap   = xpos_reg + ste_pkg::XOffset + {4'b0, cx_tile, 3'b000};
        y_wrap   = ypos_reg + ste_pkg::YOffset + {3'b0, cy_tile, 3'b000};
        sx_next  = {1'b0, x_wrap} - ste_pkg::ScrBias;
        sy_next  = {1'b0, y_wrap} - ste_pkg::ScrBias;
        code_next = base_reg
                  + {3'b0, row_reg, 6'b0}
                  + {10'b0, col_reg};
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.load) begin
            row_next = '0;
            col_next = '0;
        end else if (cmd.emit) begin
            if (col_end) begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
        valid_next = cmd.emit ? 1'b1 : (m_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            flip_y_reg <= word_vertical[15];
            hm1_reg    <= word_vertical[14:12];
            ypos_reg   <= word_vertical[8:0];
            opaque_reg <= word_tile[15];
            base_reg   <= word_tile[11:0];
            flip_x_reg <= word_attribute[15];
            shadow_reg <= word_attribute[14];
            wm1_reg    <= word_attribute[13:12];
            pal_reg    <= word_attribute[7:4];
            pmask_reg  <= ste_pkg::PmaskWidth'(pmask_wide - 1'b1);
            xpos_reg   <= word_horizontal[8:0];
        end
        if (cmd.emit) begin
            code_reg       <= code_next;
            sx_reg         <= sx_next;
            sy_reg         <= sy_next;
            last_reg       <= status.at_last;
            out_pal_reg    <= pal_reg;
            out_mx_reg     <= flip_x_reg;
            out_my_reg     <= flip_y_reg;
            out_pmask_reg  <= pmask_reg;
            out_shadow_reg <= shadow_reg;
            out_opaque_reg <= opaque_reg;
        end
    end

    assign m_valid         = valid_reg;
    assign m_tile_code     = code_reg;
    assign m_screen_x      = sx_reg;
    assign m_screen_y      = sy_reg;
    assign m_last_tile     = last_reg;
    assign m_palette_index = out_pal_reg;
    assign m_mirror_x      = out_mx_reg;
    assign m_mirror_y      = out_my_reg;
    assign m_priority_mask = out_pmask_reg;
    assign m_shadow_flag   = out_shadow_reg;
    assign m_opaque_flag   = out_opaque_reg;

endmodule
`default_nettype wire

[test/tb_sprite_tile_expander.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sprite_tile_expander
// Self-checking bench for the sprite tile expander. Sprite entries are offered
// from a queue; each accepted entry is expanded here into its tile commands,
// which are compared field by field with what the block puts out, under
// several patterns of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_sprite_tile_expander;

    localparam int unsigned WordWidth  = ste_pkg::WordWidth;
    localparam int unsigned CodeWidth  = ste_pkg::CodeWidth;
    localparam int unsigned PosWidth   = ste_pkg::PosWidth;
    localparam int unsigned ScrWidth   = ste_pkg::ScrWidth;
    localparam int unsigned PalWidth   = ste_pkg::PalWidth;
    localparam int unsigned PmaskWidth = ste_pkg::PmaskWidth;
    localparam int unsigned RowShift   = ste_pkg::RowShift;
    localparam logic [PosWidth-1:0] XOffset = ste_pkg::XOffset;
    localparam logic [PosWidth-1:0] YOffset = ste_pkg::YOffset;
    localparam logic [ScrWidth-1:0] ScrBias = ste_pkg::ScrBias;

    localparam int CycleLimit = 200000;
    localparam int HoldCycles = 80;    // long receiver hold-off
    localparam int DrainCycles = 40;   // quiet cycles after the last command

    // one sprite entry as it sits on the s_ side
    typedef struct packed {
        logic [WordWidth-1:0] vert;
        logic [WordWidth-1:0] tile;
        logic [WordWidth-1:0] attr;
        logic [WordWidth-1:0] horz;
    } sprite_entry_t;

    // one tile command, fields in port order
    typedef struct packed {
        logic [CodeWidth-1:0]  code;
        logic [PalWidth-1:0]   pal;
        logic [ScrWidth-1:0]   sx;
        logic [ScrWidth-1:0]   sy;
        logic                  mx;
        logic                  my;
        logic [PmaskWidth-1:0] pmask;
        logic                  shadow;
        logic                  opaque;
        logic                  last;
    } tile_cmd_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // sprite entry channel
    logic                 s_valid           = 1'b0;
    logic                 s_ready;
    logic [WordWidth-1:0] s_word_vertical   = '0;
    logic [WordWidth-1:0] s_word_tile       = '0;
    logic [WordWidth-1:0] s_word_attribute  = '0;
    logic [WordWidth-1:0] s_word_horizontal = '0;

    // tile command channel
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CodeWidth-1:0]  m_tile_code;
    logic [PalWidth-1:0]   m_palette_index;
    logic signed [9:0]     m_screen_x;
    logic signed [9:0]     m_screen_y;
    logic                  m_mirror_x;
    logic                  m_mirror_y;
    logic [PmaskWidth-1:0] m_priority_mask;
    logic                  m_shadow_flag;
    logic                  m_opaque_flag;
    logic                  m_last_tile;

    // sprites still to offer, and tile commands still owed by the block
    sprite_entry_t entry_q[$];
    tile_cmd_t     tile_q[$];

    // idling percentages of the current phase
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // long hold-off requests from the stimulus, served by the receiver
    int unsigned hold_req  = 0;
    int unsigned hold_done = 0;
    int unsigned hold_left = 0;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    sprite_tile_expander uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_word_vertical   (s_word_vertical),
        .s_word_tile       (s_word_tile),
        .s_word_attribute  (s_word_attribute),
        .s_word_horizontal (s_word_horizontal),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_tile_code       (m_tile_code),
        .m_palette_index   (m_palette_index),
        .m_screen_x        (m_screen_x),
        .m_screen_y        (m_screen_y),
        .m_mirror_x        (m_mirror_x),
        .m_mirror_y        (m_mirror_y),
        .m_priority_mask   (m_priority_mask),
        .m_shadow_flag     (m_shadow_flag),
        .m_opaque_flag     (m_opaque_flag),
        .m_last_tile       (m_last_tile)
    );

    // 10 unit period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // expected tile commands of one sprite entry
    // ------------------------------------------------------------------------
    // height and width come from the size fields plus one; the walk is row by
    // row, column by column, and only the position offsets follow the flips
    task automatic expand_sprite(input sprite_entry_t e);
        int unsigned height;
        int unsigned width;
        logic [PosWidth-1:0] cx;
        logic [PosWidth-1:0] cy;
        logic [PosWidth-1:0] wrap_x;
        logic [PosWidth-1:0] wrap_y;
        tile_cmd_t cmd;
        height = int'(e.vert[14:12]) + 1;
        width  = int'(e.attr[13:12]) + 1;
        for (int unsigned row = 0; row < height; row++) begin
            cy = e.vert[15] ? PosWidth'((height - 1 - row) * 8) : PosWidth'(row * 8);
            // 9-bit wrap first, then the shift down by the bias
            wrap_y = e.vert[8:0] + YOffset + cy;
            for (int unsigned col = 0; col < width; col++) begin
                cx = e.attr[15] ? PosWidth'((width - 1 - col) * 8) : PosWidth'(col * 8);
                wrap_x     = e.horz[8:0] + XOffset + cx;
                // code wraps at 12 bits, a row steps 64 codes
                cmd.code   = e.tile[11:0] + CodeWidth'((row << RowShift) + col);
                cmd.pal    = e.attr[7:4];
                cmd.sx     = {1'b0, wrap_x} - ScrBias;
                cmd.sy     = {1'b0, wrap_y} - ScrBias;
                cmd.mx     = e.attr[15];
                cmd.my     = e.vert[15];
                cmd.pmask  = PmaskWidth'((8'd1 << e.attr[2:0]) - 8'd1);
                cmd.shadow = e.attr[14];
                cmd.opaque = e.tile[15];
                cmd.last   = (row == height - 1) && (col == width - 1);
                tile_q.push_back(cmd);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sender: offers queued entries, predicts each one as it is taken
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : sprite_driver
        sprite_entry_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // entry taken at this edge: its commands are now owed
            if (s_valid && s_ready)
                expand_sprite({s_word_vertical, s_word_tile,
                               s_word_attribute, s_word_horizontal});
            // channel free: offer the next entry or leave a gap
            if (!s_valid || s_ready) begin
                if (entry_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = entry_q.pop_front();
                    s_valid           <= 1'b1;
                    s_word_vertical   <= nxt.vert;
                    s_word_tile       <= nxt.tile;
                    s_word_attribute  <= nxt.attr;
                    s_word_horizontal <= nxt.horz;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : tile_receiver
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_done != hold_req) begin
            hold_done <= hold_req;
            hold_left <= HoldCycles;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // checker: each taken command against the oldest owed one
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : tile_monitor
        tile_cmd_t got;
        tile_cmd_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_tile_code, m_palette_index, m_screen_x, m_screen_y,
                   m_mirror_x, m_mirror_y, m_priority_mask, m_shadow_flag,
                   m_opaque_flag, m_last_tile};
            if (tile_q.size() == 0) begin
                error_count++;
                $display("%0t: tile command with none owed: expected nothing, got code %0d",
                         $time, got.code);
            end else begin
                want = tile_q.pop_front();
                check_field("tile_code", want.code, got.code);
                check_field("palette_index", want.pal, got.pal);
                check_field("screen_x", int'($signed(want.sx)), int'($signed(got.sx)));
                check_field("screen_y", int'($signed(want.sy)), int'($signed(got.sy)));
                check_field("mirror_x", want.mx, got.mx);
                check_field("mirror_y", want.my, got.my);
                check_field("priority_mask", want.pmask, got.pmask);
                check_field("shadow_flag", want.shadow, got.shadow);
                check_field("opaque_flag", want.opaque, got.opaque);
                check_field("last_tile", want.last, got.last);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic add_sprite(input logic [15:0] vert, input logic [15:0] tile,
                              input logic [15:0] attr, input logic [15:0] horz);
        entry_q.push_back({vert, tile, attr, horz});
    endtask

    task automatic add_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            add_sprite(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // stimulus waits here until every queued entry is taken and every owed command has come back
    task automatic drain;
        @(negedge aclk);
        while (entry_q.size() != 0 || s_valid || tile_q.size() != 0)
            @(negedge aclk);
    endtask

    initial begin
        // reset held low at the start, released at an edge
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // phase 0: no idling on either side
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // smallest sprite, all fields zero
        add_sprite(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // all bits set: largest sprite, both flips, code and position wrap
        add_sprite(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        // full size without flips, then each flip alone
        add_sprite(16'h7040, 16'h0123, 16'h3055, 16'h0080);
        add_sprite(16'h7040, 16'h0123, 16'hb055, 16'h0080);
        add_sprite(16'hf040, 16'h0123, 16'h3055, 16'h0080);
        // every priority level, palette walking along
        for (int p = 0; p < 8; p++)
            add_sprite(16'h1000 | 16'(p * 4), 16'(p * 16), 16'h1000 | 16'(p * 17),
                       16'(p * 60));
        // code wrap at the top of the 12-bit range, row and column steps
        add_sprite(16'h3000, 16'h0fc1, 16'h2000, 16'h0010);
        add_sprite(16'h0000, 16'h0fff, 16'h1000, 16'h0010);
        // coordinate wrap near the right and bottom edges, and just below
        add_sprite(16'h21fa, 16'h0200, 16'h1000, 16'h01fa);
        add_sprite(16'h11f6, 16'h0200, 16'h0000, 16'h01ff);
        add_sprite(16'h01ff, 16'h8000, 16'h4000, 16'h01ff);
        // ignored bits set, same sprite as an all-zero one otherwise
        add_sprite(16'h0e00, 16'h7000, 16'h0f08, 16'hfe00);
        // shadow and opaque set together, shape otherwise random
        add_sprite(16'($urandom), 16'h8000 | 16'($urandom), 16'h4000 | 16'($urandom),
                   16'($urandom));

        // receiver holds off while entries keep coming, block fills and stalls
        hold_req = hold_req + 1;
        add_random(28);
        drain();

        // phase 1: sender idle most cycles
        send_idle_pct  = 67;
        recv_stall_pct = 0;
        add_random(28);
        drain();

        // phase 2: receiver stalling most cycles
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        add_random(27);
        drain();

        // phase 3: light idling on both sides
        send_idle_pct  = 13;
        recv_stall_pct = 13;
        add_random(27);
        drain();

        // nothing owed: watch for stray commands a while longer
        repeat (DrainCycles) @(posedge aclk);
        if (error_count == 0 && tile_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
